// File: sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, sizes and codes for the sorted key table core.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int KEY_W   = 64;
  localparam int DATA_W  = 32;
  localparam int FILL_W  = 11;
  localparam int ENTRY_W = KEY_W + 2 * DATA_W;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [DATA_W-1:0]       data_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [COUNT_W-1:0]      count_t;
  typedef logic [ENTRY_W-1:0]      entry_t;

  // item kinds
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FOUND     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: sv/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/skt_cmp.sv
// ----------------------------------------------------------------------------
// skt_cmp
// Shared key compare unit: signed less-than and equality on 64-bit keys.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cmp (
  input  wire skt_pkg::key_t a,
  input  wire skt_pkg::key_t b,
  output logic               lt,
  output logic               eq
);

  // true two's complement compare, no subtraction
  assign lt = (a < b);
  assign eq = (a == b);

endmodule

`default_nettype wire

// File: sv/sorted_key_table_insert_lookup_core.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_lookup_core
// Sorted key table with insert and linear-search lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per item: kind, key,
//   entry_offset, entry_length. Output channel (out_valid/out_ready) returns
//   exactly one word per item: status, found_offset, found_length, fill_count.
//   Entries live in one RAM (key, offset, length per row), walked row by row
//   by a small sequencer around a single key compare unit.
//   Insert walks down from the top entry, moving each entry whose key is not
//   less than the new key up by one row, and drops the new entry in the gap.
//   Lookup walks up from row 0 until the first equal key or the entry count.
//   A full table insert answers without walking the table. One item is in
//   work at a time; in_ready is high only while the sequencer is idle.
//   The output register holds a finished result until taken; a second result
//   waits in the sequencer while the receiver stalls.
//   Reset empties the table (entry count zero); no RAM clearing is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_insert_lookup_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        kind,
  input  wire logic signed [63:0]          key,
  input  wire logic        [31:0]          entry_offset,
  input  wire logic        [31:0]          entry_length,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic             [1:0]           status,
  output logic             [31:0]          found_offset,
  output logic             [31:0]          found_length,
  output logic             [10:0]          fill_count
);

  skt_pkg::state_t  state, state_next;
  skt_pkg::count_t  count, count_next;
  skt_pkg::count_t  pos, pos_next;
  skt_pkg::kind_t   kind_r;
  skt_pkg::key_t    key_r;
  skt_pkg::data_t   offset_r, length_r;
  skt_pkg::status_t res_status, res_status_next;
  skt_pkg::data_t   res_offset, res_offset_next;
  skt_pkg::data_t   res_length, res_length_next;
  logic             out_valid_next;
  logic             load_out;

  // ram signals
  logic             ram_we, ram_re, write_new;
  skt_pkg::addr_t   ram_waddr, ram_raddr;
  skt_pkg::entry_t  ram_wdata, ram_rdata;

  skt_pkg::key_t    row_key;
  skt_pkg::data_t   row_offset, row_length;
  logic             row_lt, row_eq;

  assign row_key    = ram_rdata[skt_pkg::ENTRY_W-1 -: skt_pkg::KEY_W];
  assign row_offset = ram_rdata[2*skt_pkg::DATA_W-1 -: skt_pkg::DATA_W];
  assign row_length = ram_rdata[skt_pkg::DATA_W-1:0];
  assign ram_wdata  = write_new ? {key_r, offset_r, length_r} : ram_rdata;

  skt_ram #(
    .WIDTH (skt_pkg::ENTRY_W),
    .DEPTH (skt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  skt_cmp u_cmp (
    .a  (row_key),
    .b  (key_r),
    .lt (row_lt),
    .eq (row_eq)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skt_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // work and result registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
    res_length <= res_length_next;
    if (in_valid && in_ready) begin
      kind_r   <= skt_pkg::kind_t'(kind);
      key_r    <= key;
      offset_r <= entry_offset;
      length_r <= entry_length;
    end
    if (load_out) begin
      status       <= res_status;
      found_offset <= res_offset;
      found_length <= res_length;
      fill_count   <= skt_pkg::FILL_W'(count);
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    res_status_next = res_status;
    res_offset_next = res_offset;
    res_length_next = res_length;
    in_ready        = 1'b0;
    load_out        = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    write_new       = 1'b0;
    ram_waddr       = pos[skt_pkg::ADDR_W-1:0];
    ram_raddr       = pos[skt_pkg::ADDR_W-1:0];
    out_valid_next  = out_valid && !out_ready;

    unique case (state)
      skt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_offset_next = '0;
          res_length_next = '0;
          if (skt_pkg::kind_t'(kind) == skt_pkg::KIND_INSERT) begin
            pos_next = count;
            if (count == skt_pkg::count_t'(skt_pkg::TABLE_DEPTH)) begin
              res_status_next = skt_pkg::STATUS_FULL;
              state_next      = skt_pkg::ST_FINISH;
            end else begin
              state_next = skt_pkg::ST_READ;
            end
          end else begin
            pos_next   = '0;
            state_next = skt_pkg::ST_READ;
          end
        end
      end

      skt_pkg::ST_READ: begin
        if (kind_r == skt_pkg::KIND_INSERT) begin
          if (pos == '0) begin
            // reached the bottom: new entry goes to row 0
            ram_we          = 1'b1;
            write_new       = 1'b1;
            count_next      = count + skt_pkg::count_t'(1);
            res_status_next = skt_pkg::STATUS_INSERTED;
            state_next      = skt_pkg::ST_FINISH;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = skt_pkg::ADDR_W'(pos - skt_pkg::count_t'(1));
            state_next = skt_pkg::ST_CHECK;
          end
        end else begin
          if (pos == count) begin
            res_status_next = skt_pkg::STATUS_NOT_FOUND;
            state_next      = skt_pkg::ST_FINISH;
          end else begin
            ram_re     = 1'b1;
            state_next = skt_pkg::ST_CHECK;
          end
        end
      end

      skt_pkg::ST_CHECK: begin
        if (kind_r == skt_pkg::KIND_INSERT) begin
          ram_we = 1'b1;
          if (row_lt) begin
            // row below is smaller: new entry fills the gap
            write_new       = 1'b1;
            count_next      = count + skt_pkg::count_t'(1);
            res_status_next = skt_pkg::STATUS_INSERTED;
            state_next      = skt_pkg::ST_FINISH;
          end else begin
            // move this row up by one
            pos_next   = pos - skt_pkg::count_t'(1);
            state_next = skt_pkg::ST_READ;
          end
        end else begin
          if (row_eq) begin
            res_status_next = skt_pkg::STATUS_FOUND;
            res_offset_next = row_offset;
            res_length_next = row_length;
            state_next      = skt_pkg::ST_FINISH;
          end else begin
            pos_next   = pos + skt_pkg::count_t'(1);
            state_next = skt_pkg::ST_READ;
          end
        end
      end

      skt_pkg::ST_FINISH: begin
        // hand the result word to the output register once it is free
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = skt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = skt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
